// ----- rtl/msle_pkg.sv -----
// shared constants and control structs for the median smoothed latency estimator
package msle_pkg;

    localparam int WINDOW_DEFAULT = 8;
    localparam int LAT_W          = 64;
    localparam int SAMPLE_W       = 32;
    localparam int WEIGHT_W       = 16;
    localparam int FRAC_W         = 16;
    localparam int EST_W          = SAMPLE_W + FRAC_W;
    localparam int PROD_W         = EST_W + WEIGHT_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd655;

    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] sample;
    } win_req_t;

    typedef struct packed {
        logic                done;
        logic                wrapped;
        logic [SAMPLE_W-1:0] median;
    } win_stat_t;

    typedef struct packed {
        logic                start;
        logic                wrapped;
        logic [SAMPLE_W-1:0] median;
    } sm_req_t;

    typedef struct packed {
        logic             done;
        logic [EST_W-1:0] estimate;
    } sm_stat_t;

endpackage

// ----- rtl/msle_sample_if.sv -----
// input channel carrying one latency sample per item
interface msle_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [msle_pkg::LAT_W-1:0]    latency_ns;

    modport source (output valid, output latency_ns, input ready);
    modport sink (input valid, input latency_ns, output ready);
endinterface

// ----- rtl/msle_result_if.sv -----
// output channel carrying one estimator result per item
interface msle_result_if;
    logic                            valid;
    logic                            ready;
    logic                            accepted;
    logic [msle_pkg::SAMPLE_W-1:0]   median_ns;
    logic                            smoothed_valid;
    logic [msle_pkg::EST_W-1:0]      smoothed_ns_q16;

    modport source (output valid, output accepted, output median_ns,
                    output smoothed_valid, output smoothed_ns_q16, input ready);
    modport sink (input valid, input accepted, input median_ns,
                  input smoothed_valid, input smoothed_ns_q16, output ready);
endinterface

// ----- rtl/median_smoothed_latency_estimator.sv -----
// top level of the median smoothed latency estimator: item control, weight register, result register
// a sample at or below zero goes from acceptance straight to T_OUT, where its result is loaded
//   once the result register is free; the controller then returns to T_IDLE for the next item
// a positive sample first passes the window merge pass and then the smoother on its way to T_OUT;
//   the merge pass streams the sorted copy through one memory port, one entry per cycle
// the result register lets the next item be taken while the previous result waits
// reset empties the window and sorted copy, clears the write slot and the estimate; weight is 655
module median_smoothed_latency_estimator #(
    parameter int WINDOW = msle_pkg::WINDOW_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    msle_sample_if.sink                       sample_in,
    msle_result_if.source                     result_out,
    input  logic                              cfg_we,
    input  logic [msle_pkg::WEIGHT_W-1:0]     cfg_wdata
);
    import msle_pkg::*;

    // one-hot item control
    typedef enum logic [3:0] {
        T_IDLE   = 4'b0001,
        T_WIN    = 4'b0010,
        T_SMOOTH = 4'b0100,
        T_OUT    = 4'b1000
    } top_state_t;

    top_state_t          state_reg, state_next;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                acc_reg, acc_next;
    logic                out_vld_reg, out_vld_next;
    logic                out_acc_reg;
    logic [SAMPLE_W-1:0] out_med_reg;
    logic                out_sv_reg;
    logic [EST_W-1:0]    out_est_reg;

    logic                in_fire;
    logic                positive;
    logic [SAMPLE_W-1:0] sat_sample;
    logic                out_load;

    win_req_t            win_req;
    win_stat_t           win_stat;
    sm_req_t             sm_req;
    sm_stat_t            sm_stat;

    // a sample counts only when strictly positive; anything past 32 bits clips to all ones
    assign positive   = !sample_in.latency_ns[LAT_W-1] && (sample_in.latency_ns != '0);
    assign sat_sample = (|sample_in.latency_ns[LAT_W-2:SAMPLE_W]) ? '1
                                                                  : sample_in.latency_ns[SAMPLE_W-1:0];

    assign sample_in.ready = (state_reg == T_IDLE);
    assign in_fire         = sample_in.valid && sample_in.ready;

    // window update runs only for samples that enter the ring
    assign win_req = '{start: in_fire && positive, sample: sat_sample};

    msle_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (win_req),
        .stat  (win_stat)
    );

    // smoothing follows straight on from the end of the sorted pass
    assign sm_req = '{start: win_stat.done, wrapped: win_stat.wrapped, median: win_stat.median};

    msle_smoother u_smoother (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (sm_req),
        .weight (weight_reg),
        .stat   (sm_stat)
    );

    // result register is free when empty or being drained this cycle
    assign out_load = (state_reg == T_OUT) && (!out_vld_reg || result_out.ready);

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        out_vld_next = out_vld_reg;

        unique case (state_reg)
            T_IDLE:
            begin
                if (in_fire)
                begin
                    acc_next   = positive;
                    state_next = positive ? T_WIN : T_OUT;
                end
            end
            T_WIN:
            begin
                if (win_stat.done)
                begin
                    state_next = T_SMOOTH;
                end
            end
            T_SMOOTH:
            begin
                if (sm_stat.done)
                begin
                    state_next = T_OUT;
                end
            end
            T_OUT:
            begin
                if (out_load)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            weight_reg  <= WEIGHT_RESET;
            acc_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                weight_reg <= cfg_wdata;
            end
        end
    end

    // result payload, captured as the item leaves
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_acc_reg <= acc_reg;
            out_med_reg <= win_stat.median;
            out_sv_reg  <= (sm_stat.estimate != '0);
            out_est_reg <= sm_stat.estimate;
        end
    end

    assign result_out.valid           = out_vld_reg;
    assign result_out.accepted        = out_acc_reg;
    assign result_out.median_ns       = out_med_reg;
    assign result_out.smoothed_valid  = out_sv_reg;
    assign result_out.smoothed_ns_q16 = out_est_reg;

    // the window only finishes a pass for an item this controller started
    a_win_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        win_stat.done |-> (state_reg == T_WIN))
        else $error("window pass finished outside of an item");

endmodule

// ----- rtl/msle_window.sv -----
// ring window and sorted copy in two memories, with the merge pass that finds the median
module msle_window #(
    parameter int WINDOW = msle_pkg::WINDOW_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  msle_pkg::win_req_t  req,
    output msle_pkg::win_stat_t stat
);
    import msle_pkg::*;

    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int MED_IDX = WINDOW / 2;

    typedef enum logic [2:0] {
        W_IDLE = 3'b001,
        W_OLD  = 3'b010,
        W_SCAN = 3'b100
    } win_state_t;

    logic [SAMPLE_W-1:0] ring_mem   [WINDOW];
    logic [SAMPLE_W-1:0] sorted_mem [WINDOW];
    logic [SAMPLE_W-1:0] ring_rd_q;
    logic [SAMPLE_W-1:0] sorted_rd_q;

    win_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic                ring_full_reg, ring_full_next;
    logic                sorted_init_reg, sorted_init_next;
    logic                wrapped_reg, wrapped_next;
    logic                done_reg, done_next;
    logic [SAMPLE_W-1:0] median_reg, median_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic [SAMPLE_W-1:0] old_reg, old_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]    wr_cnt_reg, wr_cnt_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                skipped_reg, skipped_next;
    logic                inserted_reg, inserted_next;
    logic                hold_vld_reg, hold_vld_next;
    logic [SAMPLE_W-1:0] hold_reg, hold_next;

    logic                ring_rd_en;
    logic                ring_we;
    logic                sorted_rd_en;
    logic                sorted_we;
    logic [SAMPLE_W-1:0] sorted_wr_data;

    logic [SAMPLE_W-1:0] scan_val;
    logic                skip_now;
    logic                ins_now;
    logic [1:0]          emit_cnt;
    logic [SAMPLE_W-1:0] emit0;

    // memories
    always_ff @(posedge clk)
    begin
        if (ring_rd_en)
        begin
            ring_rd_q <= ring_mem[slot_reg];
        end
        if (ring_we)
        begin
            ring_mem[slot_reg] <= smp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sorted_rd_en)
        begin
            sorted_rd_q <= sorted_mem[rd_cnt_reg[IDX_W-1:0]];
        end
        if (sorted_we)
        begin
            sorted_mem[wr_cnt_reg[IDX_W-1:0]] <= sorted_wr_data;
        end
    end

    // merge step: drop one copy of the evicted value, insert the new one in order
    always_comb
    begin
        scan_val = sorted_init_reg ? sorted_rd_q : '0;
        skip_now = !skipped_reg && (scan_val == old_reg);
        ins_now  = !skip_now && !inserted_reg && (smp_reg <= scan_val);
        if (skip_now)
        begin
            emit_cnt = 2'd0;
        end
        else if (ins_now)
        begin
            emit_cnt = 2'd2;
        end
        else
        begin
            emit_cnt = 2'd1;
        end
        emit0 = ins_now ? smp_reg : scan_val;
    end

    always_comb
    begin
        state_next       = state_reg;
        slot_next        = slot_reg;
        ring_full_next   = ring_full_reg;
        sorted_init_next = sorted_init_reg;
        wrapped_next     = wrapped_reg;
        done_next        = 1'b0;
        median_next      = median_reg;
        smp_next         = smp_reg;
        old_next         = old_reg;
        rd_cnt_next      = rd_cnt_reg;
        wr_cnt_next      = wr_cnt_reg;
        rd_vld_next      = rd_vld_reg;
        skipped_next     = skipped_reg;
        inserted_next    = inserted_reg;
        hold_vld_next    = hold_vld_reg;
        hold_next        = hold_reg;
        ring_rd_en       = 1'b0;
        ring_we          = 1'b0;
        sorted_rd_en     = 1'b0;
        sorted_we        = 1'b0;
        sorted_wr_data   = hold_reg;

        unique case (state_reg)
            W_IDLE:
            begin
                if (req.start)
                begin
                    ring_rd_en = 1'b1;
                    smp_next   = req.sample;
                    state_next = W_OLD;
                end
            end
            W_OLD:
            begin
                // unwritten slots count as zero until the ring has filled once
                old_next = ring_full_reg ? ring_rd_q : '0;
                ring_we  = 1'b1;
                if (slot_reg == IDX_W'(WINDOW - 1))
                begin
                    slot_next      = '0;
                    ring_full_next = 1'b1;
                    wrapped_next   = 1'b1;
                end
                else
                begin
                    slot_next    = slot_reg + 1'b1;
                    wrapped_next = 1'b0;
                end
                rd_cnt_next   = '0;
                wr_cnt_next   = '0;
                rd_vld_next   = 1'b0;
                skipped_next  = 1'b0;
                inserted_next = 1'b0;
                hold_vld_next = 1'b0;
                state_next    = W_SCAN;
            end
            W_SCAN:
            begin
                if (rd_cnt_reg != CNT_W'(WINDOW))
                begin
                    sorted_rd_en = 1'b1;
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                end
                rd_vld_next = sorted_rd_en;
                if (rd_vld_reg)
                begin
                    if (skip_now)
                    begin
                        skipped_next = 1'b1;
                    end
                    if (ins_now)
                    begin
                        inserted_next = 1'b1;
                    end
                    if (hold_vld_reg)
                    begin
                        sorted_we      = 1'b1;
                        sorted_wr_data = hold_reg;
                        hold_vld_next  = (emit_cnt != 2'd0);
                        hold_next      = emit0;
                    end
                    else if (emit_cnt != 2'd0)
                    begin
                        sorted_we      = 1'b1;
                        sorted_wr_data = emit0;
                        hold_vld_next  = (emit_cnt == 2'd2);
                        hold_next      = scan_val;
                    end
                end
                else if (rd_cnt_reg == CNT_W'(WINDOW))
                begin
                    // tail of the pass: pending entry, or new sample above all others
                    if (hold_vld_reg)
                    begin
                        sorted_we      = 1'b1;
                        sorted_wr_data = hold_reg;
                        hold_vld_next  = 1'b0;
                    end
                    else if (!inserted_reg)
                    begin
                        sorted_we      = 1'b1;
                        sorted_wr_data = smp_reg;
                        inserted_next  = 1'b1;
                    end
                    sorted_init_next = 1'b1;
                    done_next        = 1'b1;
                    state_next       = W_IDLE;
                end
                if (sorted_we)
                begin
                    wr_cnt_next = wr_cnt_reg + 1'b1;
                    if (wr_cnt_reg == CNT_W'(MED_IDX))
                    begin
                        median_next = sorted_wr_data;
                    end
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= W_IDLE;
            slot_reg        <= '0;
            ring_full_reg   <= 1'b0;
            sorted_init_reg <= 1'b0;
            wrapped_reg     <= 1'b0;
            done_reg        <= 1'b0;
            median_reg      <= '0;
            rd_cnt_reg      <= '0;
            wr_cnt_reg      <= '0;
            rd_vld_reg      <= 1'b0;
            skipped_reg     <= 1'b0;
            inserted_reg    <= 1'b0;
            hold_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            slot_reg        <= slot_next;
            ring_full_reg   <= ring_full_next;
            sorted_init_reg <= sorted_init_next;
            wrapped_reg     <= wrapped_next;
            done_reg        <= done_next;
            median_reg      <= median_next;
            rd_cnt_reg      <= rd_cnt_next;
            wr_cnt_reg      <= wr_cnt_next;
            rd_vld_reg      <= rd_vld_next;
            skipped_reg     <= skipped_next;
            inserted_reg    <= inserted_next;
            hold_vld_reg    <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg  <= smp_next;
        old_reg  <= old_next;
        hold_reg <= hold_next;
    end

    assign stat = '{done: done_reg, wrapped: wrapped_reg, median: median_reg};

    // the one-entry holding stage never has to take two entries at once
    a_hold_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == W_SCAN && rd_vld_reg && hold_vld_reg) |-> (emit_cnt != 2'd2))
        else $error("merge holding stage overflow");

    // every pass rewrites the whole sorted copy and removes the evicted value once
    a_pass_complete: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (wr_cnt_reg == CNT_W'(WINDOW) && skipped_reg && !hold_vld_reg))
        else $error("sorted pass incomplete");

endmodule

// ----- rtl/msle_smoother.sv -----
// exponential smoothing of the median in q16, three registered steps per update
module msle_smoother (
    input  logic                              clk,
    input  logic                              rst_n,
    input  msle_pkg::sm_req_t                 req,
    input  logic [msle_pkg::WEIGHT_W-1:0]     weight,
    output msle_pkg::sm_stat_t                stat
);
    import msle_pkg::*;

    typedef enum logic [1:0] {
        SM_KEEP,
        SM_LOAD,
        SM_RISE,
        SM_FALL
    } sm_mode_t;

    logic              v1_reg;
    logic              v2_reg;
    logic              done_reg;
    sm_mode_t          mode_reg, mode_next;
    logic [EST_W-1:0]  tgt_reg, tgt_next;
    logic [EST_W-1:0]  diff_reg, diff_next;
    logic [PROD_W-1:0] prod_reg;
    logic [EST_W-1:0]  est_reg, est_next;
    logic [PROD_W-1:0] prod_rnd;

    always_comb
    begin
        tgt_next = {req.median, {FRAC_W{1'b0}}};
        if (est_reg == '0)
        begin
            mode_next = req.wrapped ? SM_LOAD : SM_KEEP;
            diff_next = '0;
        end
        else if (tgt_next >= est_reg)
        begin
            mode_next = SM_RISE;
            diff_next = tgt_next - est_reg;
        end
        else
        begin
            mode_next = SM_FALL;
            diff_next = est_reg - tgt_next;
        end
    end

    // a downward step rounds its magnitude up, a ceiling on the shifted product
    assign prod_rnd = prod_reg + PROD_W'(16'hFFFF);

    always_comb
    begin
        est_next = est_reg;
        if (v2_reg)
        begin
            case (mode_reg)
                SM_LOAD: est_next = tgt_reg;
                SM_RISE: est_next = est_reg + prod_reg[PROD_W-1:FRAC_W];
                SM_FALL: est_next = est_reg - prod_rnd[PROD_W-1:FRAC_W];
                default: est_next = est_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
            est_reg  <= '0;
        end
        else
        begin
            v1_reg   <= req.start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
            est_reg  <= est_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mode_reg <= mode_next;
            tgt_reg  <= tgt_next;
            diff_reg <= diff_next;
        end
        if (v1_reg)
        begin
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(weight);
        end
    end

    assign stat = '{done: done_reg, estimate: est_reg};

    // an update moves the estimate towards the target and never past it
    a_rise_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && mode_reg == SM_RISE) |=>
            (est_reg >= $past(est_reg) && est_reg <= $past(tgt_reg)))
        else $error("upward smoothing step out of range");

    a_fall_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && mode_reg == SM_FALL) |=>
            (est_reg <= $past(est_reg) && est_reg >= $past(tgt_reg)))
        else $error("downward smoothing step out of range");

endmodule
